// ===== rtl/md5_pkg.sv =====
package md5_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenPos     = 56;
  localparam logic [7:0]  PadByte    = 8'h80;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;

  // item passed from the front end to the engine
  typedef struct packed {
    logic       has_byte;
    logic [7:0] data_byte;
    logic       end_of_message;
  } md5_item_t;

  function automatic logic [31:0] md5_k(input logic [5:0] r);
    logic [31:0] k;
    unique case (r)
      6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756; 6'd2:  k = 32'h242070db;
      6'd3:  k = 32'hc1bdceee; 6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501; 6'd8:  k = 32'h698098d8;
      6'd9:  k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] md5_s(input logic [5:0] r);
    logic [4:0] s;
    unique case ({r[5:4], r[1:0]})
      4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  // message word used by round r
  function automatic logic [3:0] md5_g(input logic [5:0] r);
    logic [3:0] g;
    unique case (r[5:4])
      2'd0: g = r[3:0];
      2'd1: g = 4'(5 * r[3:0] + 1);
      2'd2: g = 4'(3 * r[3:0] + 5);
      default: g = 4'(7 * r[3:0]);
    endcase
    return g;
  endfunction

endpackage

// ===== rtl/md5_message_digest.sv =====
// md5 message digest
// input: s_axis_tdata = data_byte, s_axis_tuser = {end_of_message, has_byte}
// an item with has_byte low and end_of_message high ends an empty or
// already complete message; an item with both low is ignored
// a byte that does not close a block is taken by the engine without leaving
// idle, so bytes stream at one per cycle between compressions; the queue registers each item
// the 64th byte of a block starts a compression (load, 64 rounds,
// fold), during which the engine takes nothing
// an end item pads one byte per cycle and
// compresses one or two blocks, then four digest items leave on m_axis,
// word 0 first, tlast on word 3
// a two-item queue sits between the input side and the compression engine,
// so the sender can run ahead while the engine works
// a stalled receiver holds the digest word steady and backs up the queue
// reset returns the chaining words to the initial values and empties all
module md5_message_digest
  import md5_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic [1:0]  s_axis_tuser,   // {end_of_message, has_byte}
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // digest_word
  output logic [1:0]  m_axis_tuser,   // word_index
  output logic        m_axis_tlast    // last_word
);

  md5_item_t in_item, q_item;
  logic      q_valid, q_ready;

  assign in_item.has_byte       = s_axis_tuser[0];
  assign in_item.data_byte      = s_axis_tdata;
  assign in_item.end_of_message = s_axis_tuser[1];

  md5_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_item_i(in_item),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  md5_engine u_engine (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_word_o(m_axis_tdata), .out_index_o(m_axis_tuser), .out_last_o(m_axis_tlast)
  );

endmodule

// ===== rtl/md5_front.sv =====
module md5_front
  import md5_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  md5_item_t in_item_i,
  output logic      q_valid_o,
  input  logic      q_ready_i,
  output md5_item_t q_item_o
);

  // two-entry queue; idle items are dropped here
  md5_item_t mem_q [2];
  logic      wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop, keep;

  assign in_ready_o = (cnt_q != 2'd2);
  assign keep       = in_item_i.has_byte | in_item_i.end_of_message;
  assign push       = in_valid_i & in_ready_o & keep;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_valid_o & q_ready_i;
  assign q_item_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
    end
  end

endmodule

// ===== rtl/md5_engine.sv =====
module md5_engine
  import md5_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  output logic        q_ready_o,
  input  md5_item_t   q_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] out_word_o,
  output logic [1:0]  out_index_o,
  output logic        out_last_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_LOAD, S_ROUND, S_FOLD, S_OUT
  } state_e;

  state_e      state_q;
  logic [31:0] w_q [16];
  logic [31:0] h_q [4];
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [63:0] bits_q;
  logic [5:0]  fill_q;
  logic [5:0]  rnd_q;
  logic        fin_q;      // finishing message
  logic        len_done_q; // length block compressed
  logic        len_blk_q;  // pad block takes the length
  logic        pad_placed_q;
  logic [1:0]  oidx_q;

  logic [31:0] f, sum, rot, wg;
  logic [5:0]  ins_pos;
  logic [7:0]  ins_byte;
  logic        ins_en;
  logic [4:0]  sh;

  always_comb begin
    unique case (rnd_q[5:4])
      2'd0: f = (b_q & c_q) | (~b_q & d_q);
      2'd1: f = (b_q & d_q) | (c_q & ~d_q);
      2'd2: f = b_q ^ c_q ^ d_q;
      default: f = c_q ^ (b_q | ~d_q);
    endcase
    wg  = w_q[md5_g(rnd_q)];
    sum = a_q + f + md5_k(rnd_q) + wg;
    sh  = md5_s(rnd_q);
    rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
  end

  assign q_ready_o   = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_word_o  = h_q[oidx_q];
  assign out_index_o = oidx_q;
  assign out_last_o  = (oidx_q == 2'd3);

  // byte write into the word store
  always_comb begin
    ins_en   = 1'b0;
    ins_pos  = fill_q;
    ins_byte = q_item_i.data_byte;
    if (state_q == S_IDLE && q_valid_i && q_item_i.has_byte) ins_en = 1'b1;
    if (state_q == S_PAD) begin
      ins_en = 1'b1;
      if (!pad_placed_q) ins_byte = PadByte;
      else if (len_blk_q && fill_q >= 6'(LenPos)) ins_byte = bits_q[8*(fill_q[2:0]) +: 8];
      else ins_byte = 8'h00;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ins_en) w_q[ins_pos[5:2]][8*ins_pos[1:0] +: 8] <= ins_byte;
    if (state_q == S_IDLE && q_valid_i && q_item_i.end_of_message &&
        !(q_item_i.has_byte && fill_q == 6'd63)) begin
      // pad byte goes after any byte taken this item
      if (q_item_i.has_byte) w_q[4'(({1'b0, fill_q} + 7'd1) >> 2)]
          [8*(2'(fill_q + 6'd1)) +: 8] <= PadByte;
      else w_q[fill_q[5:2]][8*fill_q[1:0] +: 8] <= PadByte;
    end
    if (state_q == S_LOAD) begin
      a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
    end
    if (state_q == S_ROUND) begin
      a_q <= d_q; d_q <= c_q; c_q <= b_q; b_q <= b_q + rot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      h_q[0] <= InitA; h_q[1] <= InitB; h_q[2] <= InitC; h_q[3] <= InitD;
      bits_q     <= '0;
      fill_q     <= '0;
      rnd_q      <= '0;
      fin_q      <= 1'b0;
      len_done_q <= 1'b0;
      len_blk_q  <= 1'b0;
      oidx_q     <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: if (q_valid_i) begin
          fin_q      <= q_item_i.end_of_message;
          len_done_q <= 1'b0;
          if (q_item_i.has_byte) begin
            bits_q <= bits_q + 64'd8;
            fill_q <= 6'(fill_q + 6'd1);
            if (fill_q == 6'd63) state_q <= S_LOAD;
            else if (q_item_i.end_of_message) begin
              fill_q    <= 6'(fill_q + 6'd2);
              len_blk_q <= (fill_q <= 6'd54);
              state_q   <= (fill_q == 6'd62) ? S_LOAD : S_PAD;
            end
          end else if (q_item_i.end_of_message) begin
            fill_q    <= 6'(fill_q + 6'd1);
            len_blk_q <= (fill_q <= 6'd55);
            state_q   <= (fill_q == 6'd63) ? S_LOAD : S_PAD;
          end
        end
        S_PAD: begin
          // pad byte if not yet placed, else zero fill; length bytes only in a block that holds the length
          fill_q <= 6'(fill_q + 6'd1);
          if (fill_q == 6'd63) begin
            state_q    <= S_LOAD;
            len_done_q <= len_blk_q;
          end
        end
        S_LOAD: begin
          rnd_q   <= '0;
          state_q <= S_ROUND;
        end
        S_ROUND: begin
          rnd_q <= 6'(rnd_q + 6'd1);
          if (rnd_q == 6'd63) state_q <= S_FOLD;
        end
        S_FOLD: begin
          h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
          h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
          fill_q <= '0;
          if (!fin_q) state_q <= S_IDLE;
          else if (len_done_q) begin
            oidx_q  <= '0;
            state_q <= S_OUT;
          end else begin
            // one more block for the length
            len_blk_q <= 1'b1;
            state_q   <= S_PAD;
          end
        end
        S_OUT: if (out_ready_i) begin
          oidx_q <= 2'(oidx_q + 2'd1);
          if (oidx_q == 2'd3) begin
            h_q[0] <= InitA; h_q[1] <= InitB; h_q[2] <= InitC; h_q[3] <= InitD;
            bits_q  <= '0;
            fill_q  <= '0;
            fin_q   <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // pad byte placement when a byte filled the block on the end item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pad_placed_q <= 1'b1;
    else if (state_q == S_IDLE && q_valid_i)
      pad_placed_q <= !(q_item_i.has_byte && q_item_i.end_of_message && fill_q == 6'd63);
    else if (state_q == S_PAD) pad_placed_q <= 1'b1;
  end

endmodule
